// ===== design/mkmc_pkg.sv =====
// Shared types and constants for the multi-keyword message counter.
package mkmc_pkg;

	localparam int PATTERN_BITS_DEF = 64;
	localparam int COUNT_WIDTH_DEF  = 16;
	localparam int BYTE_W           = 8;
	localparam int TABLE_DEPTH      = 1 << BYTE_W;
	localparam int HIT_COUNT_W      = 16;

	typedef logic [BYTE_W-1:0]      byte_t;
	typedef logic [HIT_COUNT_W-1:0] hit_count_t;

	// Codes of the action field
	localparam logic ACT_KEYWORD = 1'b0;
	localparam logic ACT_MESSAGE = 1'b1;

endpackage

// ===== design/mkmc_in_if.sv =====
// Input channel: keyword and message bytes.
interface mkmc_in_if;
	logic                 valid;
	logic                 ready;
	logic                 action;
	mkmc_pkg::byte_t      data_byte;
	logic                 last;

	modport source (output valid, output action, output data_byte, output last, input ready);
	modport sink   (input valid, input action, input data_byte, input last, output ready);
endinterface

// ===== design/mkmc_out_if.sv =====
// Result channel: per-message match flag and running count.
interface mkmc_out_if;
	logic                 valid;
	logic                 ready;
	logic                 message_hit;
	mkmc_pkg::hit_count_t hit_count;
	logic                 keywords_overflowed;

	modport source (output valid, output message_hit, output hit_count,
		output keywords_overflowed, input ready);
	modport sink   (input valid, input message_hit, input hit_count,
		input keywords_overflowed, output ready);
endinterface

// ===== design/multi_keyword_message_counter_top.sv =====
// Multi-keyword shift-and message matcher with a byte-indexed position table.
//
//  channel | dir | payload                                         | beat ends
//  in_ch   | in  | action, data_byte, last                         | valid & ready
//  out_ch  | out | message_hit, hit_count, keywords_overflowed     | valid & ready
//
// One byte per cycle while in_ch is not stalled. The position table is read
// at acceptance, the row is registered and used at stage 1, and a keyword
// write to the same row is forwarded. A message's result is loaded into the
// output register when its last byte leaves stage 1. Reset clears the table
// through per-row valid bits; no clearing pass. in_ch stalls only while a
// finished message waits and the output register is still full and not taken.
module multi_keyword_message_counter_top #(
	parameter int PATTERN_BITS = mkmc_pkg::PATTERN_BITS_DEF,
	parameter int COUNT_WIDTH  = mkmc_pkg::COUNT_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	mkmc_in_if.sink      in_ch,
	mkmc_out_if.source   out_ch
);
	import mkmc_pkg::*;

	localparam int FILL_W = $clog2(PATTERN_BITS + 1);

	typedef logic [PATTERN_BITS-1:0] row_t;

	// Position table
	row_t                   mem_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] row_vld_q;

	// Stage 1
	logic  vld_s1;
	logic  action_s1;
	byte_t byte_s1;
	logic  last_s1;
	row_t  rd_row_s1;
	logic  rd_vld_s1;
	logic  fwd_s1;
	row_t  fwd_row_s1;

	// Matcher state
	row_t                   act_q;
	row_t                   start_q;
	row_t                   end_q;
	logic [FILL_W-1:0]      fill_q;
	logic                   open_q;
	logic                   hit_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic                   ovf_q;

	// Output register
	logic       out_vld_q;
	logic       out_hit_q;
	hit_count_t out_cnt_q;
	logic       out_ovf_q;

	logic                   advance;
	logic                   in_fire;
	row_t                   row_s1;
	logic                   room;
	row_t                   pos_bit;
	row_t                   wdata;
	logic                   we;
	logic                   is_msg;
	logic                   produce;
	row_t                   act_nx;
	logic                   hit_nx;
	logic [COUNT_WIDTH-1:0] cnt_nx;

	always_comb begin
		produce = vld_s1 && (action_s1 == ACT_MESSAGE) && last_s1;
		advance = !(produce && out_vld_q && !out_ch.ready);
		in_fire = in_ch.valid && advance;
		is_msg  = vld_s1 && (action_s1 == ACT_MESSAGE);

		row_s1  = fwd_s1 ? fwd_row_s1 : (rd_vld_s1 ? rd_row_s1 : '0);
		room    = fill_q < FILL_W'(PATTERN_BITS);
		pos_bit = row_t'(1) << fill_q;
		wdata   = row_s1 | pos_bit;
		we      = vld_s1 && (action_s1 == ACT_KEYWORD) && room;

		act_nx  = ((act_q << 1) | start_q) & row_s1;
		hit_nx  = hit_q || (|(act_nx & end_q));
		cnt_nx  = (hit_nx && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;
	end

	assign in_ch.ready = advance;

	// Table read and write; read data registered, write at stage 1
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[byte_s1] <= wdata;
		end
		if (in_fire) begin
			rd_row_s1  <= mem_q[in_ch.data_byte];
			fwd_row_s1 <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
			fwd_s1    <= 1'b0;
		end else begin
			if (we) begin
				row_vld_q[byte_s1] <= 1'b1;
			end
			if (in_fire) begin
				rd_vld_s1 <= row_vld_q[in_ch.data_byte];
				// forward a same-row write that lands at this edge
				fwd_s1    <= we && (byte_s1 == in_ch.data_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			action_s1 <= ACT_KEYWORD;
			byte_s1   <= '0;
			last_s1   <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_ch.valid;
			if (in_ch.valid) begin
				action_s1 <= in_ch.action;
				byte_s1   <= in_ch.data_byte;
				last_s1   <= in_ch.last;
			end
		end
	end

	// Keyword loading and message matching
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= '0;
			start_q <= '0;
			end_q   <= '0;
			fill_q  <= '0;
			open_q  <= 1'b0;
			hit_q   <= 1'b0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (advance && vld_s1) begin
			if (action_s1 == ACT_KEYWORD) begin
				if (room) begin
					if (!open_q) begin
						start_q <= start_q | pos_bit;
					end
					if (last_s1) begin
						end_q <= end_q | pos_bit;
					end
					fill_q <= fill_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
				open_q <= !last_s1;
			end else if (last_s1) begin
				act_q <= '0;
				hit_q <= 1'b0;
				cnt_q <= cnt_nx;
			end else begin
				act_q <= act_nx;
				hit_q <= hit_nx;
			end
		end
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (produce && advance) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce && advance && is_msg) begin
			out_hit_q <= hit_nx;
			out_cnt_q <= HIT_COUNT_W'(cnt_nx);
			out_ovf_q <= ovf_q;
		end
	end

	assign out_ch.valid               = out_vld_q;
	assign out_ch.message_hit         = out_hit_q;
	assign out_ch.hit_count           = out_cnt_q;
	assign out_ch.keywords_overflowed = out_ovf_q;

endmodule

// ===== bench/mkmc_checker.sv =====
// Checker for the keyword message counter: predicts verdicts from input beats and compares.
`timescale 1ns / 1ps
module mkmc_checker #(
	parameter int PATTERN_BITS = mkmc_pkg::PATTERN_BITS_DEF,
	parameter int COUNT_WIDTH  = mkmc_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mkmc_in_if   in_ch,
	mkmc_out_if  out_ch,
	output int   fail_count,
	output int   outstanding
);
	import mkmc_pkg::*;

	typedef logic [PATTERN_BITS-1:0] posvec_t;
	typedef logic [COUNT_WIDTH-1:0]  tally_t;

	typedef struct {
		logic       hit;
		hit_count_t count;
		logic       ovf;
	} verdict_t;

	// Shift-and matcher state
	posvec_t     row_bits [TABLE_DEPTH];
	posvec_t     active_vec;
	posvec_t     start_vec;
	posvec_t     end_vec;
	int unsigned fill_pos;
	logic        kw_open;
	logic        msg_hit;
	logic        ovf_flag;
	tally_t      hits_seen;

	verdict_t    verdict_q [$];

	always @(posedge clk or negedge arst_n) begin
		int       errs;
		verdict_t want;
		posvec_t  pos_bit;
		byte_t    b;
		if (!arst_n) begin
			for (int r = 0; r < TABLE_DEPTH; r++)
				row_bits[r] = '0;
			active_vec  = '0;
			start_vec   = '0;
			end_vec     = '0;
			fill_pos    = 0;
			kw_open     = 1'b0;
			msg_hit     = 1'b0;
			ovf_flag    = 1'b0;
			hits_seen   = '0;
			verdict_q.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				if (verdict_q.size() == 0) begin
					$error("result beat with no message pending: message_hit %0d hit_count %0d",
						out_ch.message_hit, out_ch.hit_count);
					errs++;
				end else begin
					want = verdict_q.pop_front();
					if (out_ch.message_hit !== want.hit) begin
						$error("message_hit expected %0d actual %0d", want.hit, out_ch.message_hit);
						errs++;
					end
					if (out_ch.hit_count !== want.count) begin
						$error("hit_count expected %0d actual %0d", want.count, out_ch.hit_count);
						errs++;
					end
					if (out_ch.keywords_overflowed !== want.ovf) begin
						$error("keywords_overflowed expected %0d actual %0d",
							want.ovf, out_ch.keywords_overflowed);
						errs++;
					end
				end
			end
			if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
				b = in_ch.data_byte;
				if (in_ch.action == ACT_KEYWORD) begin
					// Pack into the next free position, drop once the table is full
					if (fill_pos < PATTERN_BITS) begin
						pos_bit = posvec_t'(1) << fill_pos;
						row_bits[b] = row_bits[b] | pos_bit;
						if (!kw_open)
							start_vec = start_vec | pos_bit;
						if (in_ch.last)
							end_vec = end_vec | pos_bit;
						fill_pos++;
					end else begin
						ovf_flag = 1'b1;
					end
					kw_open = !in_ch.last;
				end else begin
					active_vec = ((active_vec << 1) | start_vec) & row_bits[b];
					if ((active_vec & end_vec) != '0)
						msg_hit = 1'b1;
					if (in_ch.last) begin
						if (msg_hit && hits_seen != '1)
							hits_seen = hits_seen + 1'b1;
						want.hit   = msg_hit;
						want.count = hit_count_t'(hits_seen);
						want.ovf   = ovf_flag;
						verdict_q.push_back(want);
						active_vec = '0;
						msg_hit    = 1'b0;
					end
				end
			end
			fail_count  <= fail_count + errs;
			outstanding <= verdict_q.size();
		end
	end

endmodule

// ===== bench/multi_keyword_message_counter_top_tb.sv =====
// Testbench top for the keyword message counter: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module multi_keyword_message_counter_top_tb;
	import mkmc_pkg::*;

	typedef struct {
		logic  action;
		byte_t data;
		logic  last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int   accepted_beats = 0;

	beat_t beat_q [$];

	// Keywords sent so far, for embedding in messages
	byte_t kw_text [32][8];
	int    kw_len  [32];
	int    kw_count = 0;

	mkmc_in_if  in_ch ();
	mkmc_out_if out_ch ();

	multi_keyword_message_counter_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	mkmc_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic push_beat(input logic action, input byte_t data, input logic last);
		beat_t bt;
		bt.action = action;
		bt.data   = data;
		bt.last   = last;
		beat_q.push_back(bt);
	endtask

	// Mostly a small alphabet so keywords recur, sometimes any byte
	function automatic byte_t pick_byte();
		if ($urandom_range(0, 7) == 0)
			return byte_t'($urandom_range(0, 255));
		return byte_t'("a" + $urandom_range(0, 3));
	endfunction

	// Build the stimulus: directed opening, then random keyword and message sequences
	task automatic build_stimulus();
		int    roll;
		int    len;
		int    pick;
		int    kw_bytes;
		int    cut;
		byte_t b;
		byte_t msg [$];
		// Message before any keyword
		push_beat(ACT_MESSAGE, "x", 1'b1);
		push_beat(ACT_KEYWORD, "a", 1'b0);
		push_beat(ACT_KEYWORD, "b", 1'b1);
		push_beat(ACT_KEYWORD, 8'h00, 1'b1);
		push_beat(ACT_KEYWORD, " ", 1'b0);
		push_beat(ACT_KEYWORD, "*", 1'b1);
		push_beat(ACT_MESSAGE, "x", 1'b0);
		push_beat(ACT_MESSAGE, "a", 1'b0);
		push_beat(ACT_MESSAGE, "b", 1'b1);
		push_beat(ACT_MESSAGE, 8'hFF, 1'b1);
		// Keyword arriving in the middle of a message
		push_beat(ACT_MESSAGE, " ", 1'b0);
		push_beat(ACT_KEYWORD, 8'hFF, 1'b1);
		push_beat(ACT_MESSAGE, "*", 1'b1);
		push_beat(ACT_MESSAGE, 8'hFF, 1'b1);
		// Unfinished keyword must not hit
		push_beat(ACT_KEYWORD, "q", 1'b0);
		push_beat(ACT_MESSAGE, "q", 1'b1);
		push_beat(ACT_MESSAGE, 8'h00, 1'b1);
		kw_text[0][0] = "a";
		kw_text[0][1] = "b";
		kw_len[0]     = 2;
		kw_text[1][0] = " ";
		kw_text[1][1] = "*";
		kw_len[1]     = 2;
		kw_count      = 2;
		kw_bytes      = 7;

		while (beat_q.size() < 925) begin
			roll = $urandom_range(0, 99);
			if (roll < 20 && kw_bytes < 90) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					b = pick_byte();
					if (kw_count < 32)
						kw_text[kw_count][i] = b;
					// Leave some keywords open so the next one runs on
					push_beat(ACT_KEYWORD, b, (i == len - 1) && (roll < 18));
				end
				if (kw_count < 32) begin
					kw_len[kw_count] = len;
					kw_count++;
				end
				kw_bytes += len;
			end else begin
				msg.delete();
				len = $urandom_range(0, 5);
				for (int i = 0; i < len; i++)
					msg.push_back(pick_byte());
				if ($urandom_range(0, 1) == 1) begin
					pick = $urandom_range(0, kw_count - 1);
					cut  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, kw_len[pick]) :
						kw_len[pick];
					for (int i = 0; i < cut; i++)
						msg.push_back(kw_text[pick][i]);
				end
				len = $urandom_range(0, 5);
				for (int i = 0; i < len; i++)
					msg.push_back(pick_byte());
				if (msg.size() == 0)
					msg.push_back(pick_byte());
				foreach (msg[i]) begin
					if ($urandom_range(0, 24) == 0)
						push_beat(ACT_KEYWORD, pick_byte(), logic'($urandom_range(0, 1)));
					push_beat(ACT_MESSAGE, msg[i], i == msg.size() - 1);
				end
			end
		end
	endtask

	// Sender: bursts of random length separated by random gaps
	initial begin : source_side
		int    burst_left;
		beat_t bt;
		in_ch.valid     = 1'b0;
		in_ch.action    = ACT_KEYWORD;
		in_ch.data_byte = '0;
		in_ch.last      = 1'b0;
		arst_n          = 1'b0;
		build_stimulus();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		burst_left = $urandom_range(1, 12);
		while (beat_q.size() > 0) begin
			bt = beat_q.pop_front();
			if (burst_left == 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) :
					$urandom_range(1, 12);
			end
			in_ch.valid     <= 1'b1;
			in_ch.action    <= bt.action;
			in_ch.data_byte <= bt.data;
			in_ch.last      <= bt.last;
			@(posedge clk);
			while (in_ch.ready !== 1'b1)
				@(posedge clk);
			accepted_beats++;
			burst_left--;
			@(negedge clk);
		end
		in_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: stall pattern changes every span; one long hold-off to back up the input
	initial begin : sink_side
		int mode;
		int span;
		int hold_left;
		int cycle;
		bit held;
		out_ch.ready = 1'b0;
		mode      = 0;
		span      = 0;
		hold_left = 0;
		cycle     = 0;
		held      = 1'b0;
		forever begin
			@(negedge clk);
			cycle++;
			if (!held && accepted_beats >= 300) begin
				held      = 1'b1;
				hold_left = 200;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 80);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= logic'($urandom_range(0, 1));
					2: out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: out_ch.ready <= logic'(cycle[1]);
				endcase
			end
		end
	end

	initial begin : watchdog
		#200_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
